/* src/pagerank_csr_power_iteration_top_assert.svh */
// Assertion macros for the PageRank CSR block.
// Used by pagerank_csr_power_iteration_top; needs clk and rst_n in scope.
`ifndef PAGERANK_CSR_POWER_ITERATION_TOP_ASSERT_SVH
`define PAGERANK_CSR_POWER_ITERATION_TOP_ASSERT_SVH

// Same-cycle implication, checked out of reset.
`define PRC_ASSERT_NOW(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked out of reset.
`define PRC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

/* src/prcsr_pkg.sv */
// Package for the PageRank CSR block: sizes, op codes, register indexes, a saturating helper.
// No dependencies.
package prcsr_pkg;

  localparam int V_MAX = 1024;
  localparam int E_MAX = 16384;
  localparam int VW    = $clog2(V_MAX);     // vertex address bits
  localparam int EW    = $clog2(E_MAX);     // edge address bits
  localparam int RW    = $clog2(V_MAX + 1); // row slot address bits

  typedef enum logic [1:0] {
    OP_LOAD_ROW  = 2'd0,
    OP_LOAD_EDGE = 2'd1,
    OP_RUN       = 2'd2,
    OP_READ      = 2'd3
  } op_t;

  typedef enum logic [1:0] {
    REG_VCOUNT  = 2'd0,
    REG_DAMPING = 2'd1,
    REG_EPSILON = 2'd2,
    REG_MAXITER = 2'd3
  } reg_idx_t;

  function automatic logic [31:0] sat32(input logic [32:0] x);
    sat32 = x[32] ? 32'hFFFF_FFFF : x[31:0];
  endfunction

endpackage

/* src/pagerank_csr_power_iteration_top.sv */
// PageRank power iteration over a CSR graph held in on-chip memories.
// Depends on prcsr_pkg and pagerank_csr_power_iteration_top_assert.svh.
//
// Load items (row offset, edge target) are taken one per cycle while the
// block is idle. A read item passes through its read-wait state, and its
// result is registered onto the output once the output is free. A run
// item is sequenced over single-port-per-side memories: two divisions for
// the start and teleport values, a fill of all V ranks, and per pass a copy
// to the previous ranks, pass control and a check, per vertex an offset
// read and product plus a division when it has out-edges, an edge fetch and
// rank read-modify-write per edge, and an L1 sum. The shared serial divider
// and the one-entry-at-a-time rank update set the length of a run.
`include "pagerank_csr_power_iteration_top_assert.svh"

module pagerank_csr_power_iteration_top (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic [1:0]  cfg_index,
  input  logic [31:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [1:0]  in_op,
  input  logic [13:0] in_index,
  input  logic [14:0] in_value,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [31:0] out_rank_value,
  output logic [15:0] out_passes_done,
  output logic        out_converged
);

  localparam int VW = prcsr_pkg::VW;
  localparam int EW = prcsr_pkg::EW;
  localparam int RW = prcsr_pkg::RW;

  typedef enum logic [4:0] {
    S_IDLE, S_RW, S_I0, S_I1, S_I2, S_I3, S_FILL, S_PASS, S_C0, S_C1,
    S_V0, S_V1, S_V2, S_MUL, S_DW, S_E0, S_E1, S_E2, S_D0, S_D1, S_CHK
  } state_t;

  // configuration
  logic [10:0] vcount_r;
  logic [15:0] damp_r, maxit_r;
  logic [31:0] eps_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vcount_r <= 11'd1;
      damp_r   <= 16'd55705;
      eps_r    <= 32'd4295;
      maxit_r  <= 16'd100;
    end else if (cfg_we) begin
      case (prcsr_pkg::reg_idx_t'(cfg_index))
        prcsr_pkg::REG_VCOUNT:  vcount_r <= cfg_data[10:0];
        prcsr_pkg::REG_DAMPING: damp_r   <= cfg_data[15:0];
        prcsr_pkg::REG_EPSILON: eps_r    <= cfg_data;
        prcsr_pkg::REG_MAXITER: maxit_r  <= cfg_data[15:0];
        default: ;
      endcase
    end
  end

  logic [10:0] v_eff;
  always_comb begin
    if (vcount_r == 11'd0) v_eff = 11'd1;
    else if (vcount_r > 11'(prcsr_pkg::V_MAX)) v_eff = 11'(prcsr_pkg::V_MAX);
    else v_eff = vcount_r;
  end

  // control
  state_t      st_r;
  logic [10:0] i_r;
  logic [14:0] j_r, start_r, end_r, deg_r;
  logic [VW-1:0] t_r;
  logic [31:0] init_r, tele_r, share_r;
  logic [47:0] prod_r;
  logic [42:0] diff_r;
  logic [15:0] passes_r;
  logic        conv_r, rd_ok_r;
  logic        out_valid_r;
  logic [31:0] out_rank_r;
  logic [15:0] out_pass_r;
  logic        out_conv_r;

  logic acc;
  assign in_ready = (st_r == S_IDLE);
  assign acc      = in_valid && in_ready;

  // memories
  logic [14:0] row_mem  [prcsr_pkg::V_MAX+1];
  logic [14:0] edge_mem [prcsr_pkg::E_MAX];
  logic [31:0] rank_mem [prcsr_pkg::V_MAX];
  logic [31:0] prev_mem [prcsr_pkg::V_MAX];
  logic [14:0] row_q, edge_q;
  logic [31:0] rank_q, prev_q;

  logic [RW-1:0] row_ra;
  logic [VW-1:0] rank_ra, rank_wa;
  logic          rank_we, prev_we;
  logic [31:0]   rank_wd;
  logic [32:0]   rank_sum;

  assign row_ra   = RW'(i_r) + RW'(st_r == S_V1);
  assign rank_sum = {1'b0, rank_q} + {1'b0, share_r};

  always_comb begin
    if (st_r == S_E1) rank_ra = edge_q[VW-1:0];
    else if (st_r == S_IDLE) rank_ra = in_index[VW-1:0];
    else rank_ra = i_r[VW-1:0];
  end

  always_comb begin
    rank_we = 1'b0;
    rank_wa = i_r[VW-1:0];
    rank_wd = tele_r;
    case (st_r)
      S_FILL: begin
        rank_we = 1'b1;
        rank_wd = init_r;
      end
      S_C1: rank_we = 1'b1;
      S_E2: begin
        rank_we = 1'b1;
        rank_wa = t_r;
        rank_wd = prcsr_pkg::sat32(rank_sum);
      end
      default: ;
    endcase
  end
  assign prev_we = (st_r == S_C1);

  always_ff @(posedge clk) begin
    if (acc && in_op == prcsr_pkg::OP_LOAD_ROW && in_index <= 14'(prcsr_pkg::V_MAX))
      row_mem[in_index[RW-1:0]] <= in_value;
    row_q <= row_mem[row_ra];
  end

  always_ff @(posedge clk) begin
    if (acc && in_op == prcsr_pkg::OP_LOAD_EDGE)
      edge_mem[in_index[EW-1:0]] <= in_value;
    edge_q <= edge_mem[j_r[EW-1:0]];
  end

  // the read item's rank is held while its result waits for the output
  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[rank_wa] <= rank_wd;
    if (st_r != S_RW) rank_q <= rank_mem[rank_ra];
  end

  always_ff @(posedge clk) begin
    if (prev_we) prev_mem[i_r[VW-1:0]] <= rank_q;
    prev_q <= prev_mem[i_r[VW-1:0]];
  end

  // bit-serial restoring divider, 33-bit dividend, 15-bit divisor
  logic        dv_start, dv_busy_r;
  logic [32:0] dv_dnd, dv_quo_r;
  logic [14:0] dv_dsr, dv_dsr_r, dv_rem_r;
  logic [5:0]  dv_cnt_r;
  logic [15:0] dv_tmp, dv_sub;
  logic        dv_ge;

  always_comb begin
    dv_start = 1'b0;
    dv_dnd   = 33'h1_0000_0000;
    dv_dsr   = {4'd0, v_eff};
    case (st_r)
      S_I0: dv_start = 1'b1;
      S_I2: begin
        dv_start = 1'b1;
        dv_dnd   = {17'h1_0000 - {1'b0, damp_r}, 16'd0};
      end
      S_MUL: begin
        dv_start = 1'b1;
        dv_dnd   = {1'b0, prod_r[47:16]};
        dv_dsr   = deg_r;
      end
      default: ;
    endcase
  end

  assign dv_tmp = {dv_rem_r, dv_quo_r[32]};
  assign dv_ge  = dv_tmp >= {1'b0, dv_dsr_r};
  assign dv_sub = dv_tmp - {1'b0, dv_dsr_r};

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dv_busy_r <= 1'b0;
    end else if (dv_start) begin
      dv_busy_r <= 1'b1;
      dv_quo_r  <= dv_dnd;
      dv_rem_r  <= '0;
      dv_dsr_r  <= dv_dsr;
      dv_cnt_r  <= '0;
    end else if (dv_busy_r) begin
      dv_rem_r <= dv_ge ? dv_sub[14:0] : dv_tmp[14:0];
      dv_quo_r <= {dv_quo_r[31:0], dv_ge};
      dv_cnt_r <= dv_cnt_r + 6'd1;
      if (dv_cnt_r == 6'd32) dv_busy_r <= 1'b0;
    end
  end

  // sequencer
  logic [14:0] row_clamp;
  logic [31:0] absd;
  logic        last_v, last_e;
  assign row_clamp = (row_q > 15'(prcsr_pkg::E_MAX)) ? 15'(prcsr_pkg::E_MAX) : row_q;
  assign absd      = (rank_q >= prev_q) ? rank_q - prev_q : prev_q - rank_q;
  assign last_v    = (i_r + 11'd1 == v_eff);
  assign last_e    = (j_r + 15'd1 == end_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r        <= S_IDLE;
      passes_r    <= '0;
      conv_r      <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      if (st_r == S_RW && (!out_valid_r || out_ready)) out_valid_r <= 1'b1;
      else if (out_valid_r && out_ready) out_valid_r <= 1'b0;
      case (st_r)
        S_IDLE: if (acc) begin
          if (in_op == prcsr_pkg::OP_READ) begin
            rd_ok_r <= (in_index < {3'd0, v_eff});
            st_r    <= S_RW;
          end else if (in_op == prcsr_pkg::OP_RUN) begin
            passes_r <= '0;
            conv_r   <= 1'b0;
            st_r     <= S_I0;
          end
        end
        S_RW: if (!out_valid_r || out_ready) begin
          out_rank_r  <= rd_ok_r ? rank_q : 32'd0;
          out_pass_r  <= passes_r;
          out_conv_r  <= conv_r;
          st_r        <= S_IDLE;
        end
        S_I0: st_r <= S_I1;
        S_I1: if (!dv_busy_r) begin
          init_r <= prcsr_pkg::sat32(dv_quo_r);
          st_r   <= S_I2;
        end
        S_I2: st_r <= S_I3;
        S_I3: if (!dv_busy_r) begin
          tele_r <= prcsr_pkg::sat32(dv_quo_r);
          i_r    <= '0;
          st_r   <= S_FILL;
        end
        S_FILL: begin
          i_r <= i_r + 11'd1;
          if (last_v) st_r <= (maxit_r == 16'd0) ? S_IDLE : S_PASS;
        end
        S_PASS: begin
          i_r    <= '0;
          diff_r <= '0;
          st_r   <= S_C0;
        end
        S_C0: st_r <= S_C1;
        S_C1: begin
          if (last_v) begin
            i_r  <= '0;
            st_r <= S_V0;
          end else begin
            i_r  <= i_r + 11'd1;
            st_r <= S_C0;
          end
        end
        S_V0: st_r <= S_V1;
        S_V1: begin
          start_r <= row_clamp;
          st_r    <= S_V2;
        end
        S_V2: begin
          if (row_clamp <= start_r) begin
            if (last_v) begin
              i_r  <= '0;
              st_r <= S_D0;
            end else begin
              i_r  <= i_r + 11'd1;
              st_r <= S_V0;
            end
          end else begin
            end_r  <= row_clamp;
            deg_r  <= row_clamp - start_r;
            j_r    <= start_r;
            prod_r <= damp_r * prev_q;
            st_r   <= S_MUL;
          end
        end
        S_MUL: st_r <= S_DW;
        S_DW: if (!dv_busy_r) begin
          share_r <= prcsr_pkg::sat32(dv_quo_r);
          st_r    <= S_E0;
        end
        S_E0: st_r <= S_E1;
        S_E1, S_E2: begin
          if (st_r == S_E1 && edge_q < {4'd0, v_eff}) begin
            t_r  <= edge_q[VW-1:0];
            st_r <= S_E2;
          end else if (!last_e) begin
            j_r  <= j_r + 15'd1;
            st_r <= S_E0;
          end else if (last_v) begin
            i_r  <= '0;
            st_r <= S_D0;
          end else begin
            i_r  <= i_r + 11'd1;
            st_r <= S_V0;
          end
        end
        S_D0: st_r <= S_D1;
        S_D1: begin
          diff_r <= diff_r + {11'd0, absd};
          if (last_v) st_r <= S_CHK;
          else begin
            i_r  <= i_r + 11'd1;
            st_r <= S_D0;
          end
        end
        S_CHK: begin
          passes_r <= passes_r + 16'd1;
          if (diff_r < {11'd0, eps_r}) begin
            conv_r <= 1'b1;
            st_r   <= S_IDLE;
          end else if (passes_r + 16'd1 < maxit_r) begin
            st_r <= S_PASS;
          end else begin
            st_r <= S_IDLE;
          end
        end
        default: st_r <= S_IDLE;
      endcase
    end
  end

  assign out_valid       = out_valid_r;
  assign out_rank_value  = out_rank_r;
  assign out_passes_done = out_pass_r;
  assign out_converged   = out_conv_r;

  `PRC_ASSERT_NOW(a_div_free, dv_start, !dv_busy_r, "divider restarted while busy")
  `PRC_ASSERT_NOW(a_deg_nz, st_r == S_MUL, deg_r != 15'd0, "zero outdegree sent to divider")
  `PRC_ASSERT_NOW(a_edge_rng, st_r == S_E0, j_r < end_r, "edge index past row end")
  `PRC_ASSERT_NXT(a_tgt_rng, st_r == S_E1 && edge_q < {4'd0, v_eff},
                  {1'b0, t_r} < v_eff, "rank update target out of range")

endmodule

/* tb/tb_pagerank_csr_power_iteration_top.sv */
// Self-checking testbench for pagerank_csr_power_iteration_top: CSR loads, runs, rank reads.
// Depends on prcsr_pkg. A local rank predictor, or a typed value, checks each read.
module tb_pagerank_csr_power_iteration_top;

  localparam int CYCLE_LIMIT = 3000000;
  localparam int ITEM_GOAL   = 650;
  localparam int V_MAX       = prcsr_pkg::V_MAX;
  localparam int E_MAX       = prcsr_pkg::E_MAX;

  typedef struct packed {
    logic [31:0] rank;
    logic [15:0] passes;
    logic        conv;
  } rank_rd_t;

  typedef struct {
    prcsr_pkg::op_t op;
    logic [13:0] idx;
    logic [14:0] val;
    bit          typed;
    rank_rd_t    res;
  } dir_row_t;

  logic        clk, rst_n;
  logic        cfg_we;
  prcsr_pkg::reg_idx_t cfg_index;
  logic [31:0] cfg_data;
  logic        in_valid, in_ready;
  prcsr_pkg::op_t in_op;
  logic [13:0] in_index;
  logic [14:0] in_value;
  logic        out_valid, out_ready;
  logic [31:0] out_rank_value;
  logic [15:0] out_passes_done;
  logic        out_converged;

  pagerank_csr_power_iteration_top uut (
    .clk, .rst_n, .cfg_we, .cfg_index, .cfg_data,
    .in_valid, .in_ready, .in_op, .in_index, .in_value,
    .out_valid, .out_ready, .out_rank_value, .out_passes_done, .out_converged
  );

  // predictor state
  logic [10:0] m_vcount;
  logic [15:0] m_damp;
  logic [31:0] m_eps;
  logic [15:0] m_maxit;
  logic [14:0] m_row [0:V_MAX];
  logic [14:0] m_edge [0:E_MAX-1];
  logic [31:0] m_rank [0:V_MAX-1];
  logic [31:0] m_prev [0:V_MAX-1];
  bit          m_rank_ok [0:V_MAX-1];
  logic [15:0] m_passes;
  logic        m_conv;

  rank_rd_t rd_expect_q[$];
  int  errors, n_items, n_reads, n_runs, cycles;
  bit  quiet, hold_req;

  initial begin
    clk = 0;
    forever #6 clk = ~clk;
  end

  always @(posedge clk) begin
    cycles <= cycles + 1;
    if (cycles > CYCLE_LIMIT) begin
      $display("timeout after %0d cycles", cycles);
      $display("Regression FAIL");
      $finish;
    end
  end

  function automatic int unsigned eff_v();
    if (m_vcount == 0) return 1;
    if (m_vcount > V_MAX) return V_MAX;
    return m_vcount;
  endfunction

  function automatic logic [31:0] clip32(longint unsigned x);
    return (x > 64'hFFFF_FFFF) ? 32'hFFFF_FFFF : x[31:0];
  endfunction

  function automatic int unsigned edge_clip(logic [14:0] x);
    return (x > E_MAX) ? E_MAX : x;
  endfunction

  function automatic void pagerank_run();
    int unsigned v, lim, s, e, deg, t;
    longint unsigned dd, tele, init, diff, share;
    v = eff_v();
    dd = m_damp;
    tele = clip32(((65536 - dd) << 16) / v);
    init = clip32((64'd1 << 32) / v);
    lim = m_maxit;
    m_passes = 0;
    m_conv = 0;
    for (int i = 0; i < v; i++) begin
      m_rank[i] = init;
      m_rank_ok[i] = 1;
    end
    for (int p = 0; p < lim; p++) begin
      diff = 0;
      for (int i = 0; i < v; i++) begin
        m_prev[i] = m_rank[i];
        m_rank[i] = tele;
      end
      for (int i = 0; i < v; i++) begin
        s = edge_clip(m_row[i]);
        e = edge_clip(m_row[i+1]);
        if (e > s) begin
          deg = e - s;
          share = ((dd * m_prev[i]) >> 16) / deg;
          for (int j = s; j < e; j++) begin
            t = m_edge[j];
            if (t < v) m_rank[t] = clip32(longint'(m_rank[t]) + share);
          end
        end
      end
      for (int i = 0; i < v; i++)
        diff += (m_rank[i] >= m_prev[i]) ? m_rank[i] - m_prev[i] : m_prev[i] - m_rank[i];
      m_passes = p + 1;
      if (diff < m_eps) begin
        m_conv = 1;
        break;
      end
    end
  endfunction

  function automatic rank_rd_t predict_read(logic [13:0] idx);
    rank_rd_t r;
    r.rank = (idx < eff_v()) ? m_rank[idx] : 32'd0;
    r.passes = m_passes;
    r.conv = m_conv;
    return r;
  endfunction

  // Drives one item and waits for its acceptance; typed results override the predictor.
  task automatic send(prcsr_pkg::op_t op, logic [13:0] idx, logic [14:0] val,
                      bit typed = 0, rank_rd_t tres = '0);
    rank_rd_t r;
    if (!quiet && $urandom_range(0, 4) == 0) begin
      in_valid <= 1'b0;
      repeat ($urandom_range(1, 19)) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_index <= idx;
    in_value <= val;
    do @(posedge clk); while (!in_ready);
    n_items++;
    case (op)
      prcsr_pkg::OP_LOAD_ROW:  if (idx <= V_MAX) m_row[idx] = val;
      prcsr_pkg::OP_LOAD_EDGE: m_edge[idx] = val;
      prcsr_pkg::OP_RUN: begin
        pagerank_run();
        n_runs++;
      end
      default: begin
        r = predict_read(idx);
        rd_expect_q.push_back(typed ? tres : r);
        n_reads++;
      end
    endcase
  endtask

  // Writes all four registers once the block has gone idle.
  task automatic set_config(logic [10:0] v, logic [15:0] d, logic [31:0] eps,
                            logic [15:0] mi);
    in_valid <= 1'b0;
    wait (rd_expect_q.size() == 0);
    repeat (40) @(posedge clk);
    for (int i = 0; i < 4; i++) begin
      cfg_we <= 1'b1;
      cfg_index <= prcsr_pkg::reg_idx_t'(i);
      case (i)
        prcsr_pkg::REG_VCOUNT:  cfg_data <= v;
        prcsr_pkg::REG_DAMPING: cfg_data <= d;
        prcsr_pkg::REG_EPSILON: cfg_data <= eps;
        default:                cfg_data <= mi;
      endcase
      @(posedge clk);
    end
    cfg_we <= 1'b0;
    m_vcount = v;
    m_damp = d;
    m_eps = eps;
    m_maxit = mi;
  endtask

  task automatic read_any();
    int unsigned v;
    logic [13:0] idx;
    v = eff_v();
    idx = $urandom_range(0, 16383);
    if (idx < v && !m_rank_ok[idx]) idx = v + idx % (16384 - v);
    send(prcsr_pkg::OP_READ, idx, $urandom);
  endtask

  // One random graph: config, offsets, edges, an optional read, a run, then reads.
  task automatic random_graph(bit stall_reads);
    int unsigned v, base, lo, hi;
    int o [0:40];
    logic [15:0] d, mi;
    logic [31:0] eps;
    v = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(2, 8);
    case ($urandom_range(0, 5))
      0: d = 16'd0;
      1: d = 16'hFFFF;
      default: d = $urandom;
    endcase
    case ($urandom_range(0, 5))
      0: eps = 32'd0;
      1: eps = 32'hFFFF_FFFF;
      2: eps = $urandom_range(0, 100000);
      default: eps = $urandom;
    endcase
    case ($urandom_range(0, 7))
      0: mi = 16'd0;
      1: mi = (v <= 4) ? 16'd40 : 16'd12;
      default: mi = $urandom_range(1, 12);
    endcase
    set_config(v, d, eps, mi);
    base = $urandom_range(200, 16000);
    o[0] = base;
    for (int i = 0; i < v; i++)
      o[i+1] = ($urandom_range(0, 7) == 0) ? o[i] - 1 : o[i] + $urandom_range(0, 4);
    lo = base;
    hi = base;
    for (int i = 0; i <= v; i++) begin
      if (o[i] < lo) lo = o[i];
      if (o[i] > hi) hi = o[i];
      send(prcsr_pkg::OP_LOAD_ROW, i, o[i]);
      if ($urandom_range(0, 9) == 0)
        send(prcsr_pkg::OP_LOAD_ROW, $urandom_range(V_MAX + 1, 16383), $urandom);
    end
    for (int j = lo; j < hi; j++)
      send(prcsr_pkg::OP_LOAD_EDGE, j,
           ($urandom_range(0, 7) == 0) ? $urandom : $urandom_range(0, v - 1));
    if ($urandom_range(0, 3) == 0) read_any();
    send(prcsr_pkg::OP_RUN, $urandom, $urandom);
    if (stall_reads) hold_req = 1;
    for (int i = 0; i < v; i++) send(prcsr_pkg::OP_READ, i, $urandom);
    repeat (stall_reads ? 20 : 2) read_any();
  endtask

  // result side: random stalls, one long hold-off on request
  initial begin
    out_ready <= 1'b0;
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        out_ready <= 1'b0;
        for (int k = 0; k < 400; k++) @(posedge clk);
        hold_req = 0;
        out_ready <= 1'b1;
      end else if (!quiet && $urandom_range(0, 5) == 0) begin
        out_ready <= 1'b0;
        repeat ($urandom_range(1, 19)) @(posedge clk);
        out_ready <= 1'b1;
      end else begin
        out_ready <= 1'b1;
      end
    end
  end

  always @(posedge clk) begin
    rank_rd_t x;
    if (rst_n && out_valid && out_ready) begin
      if (rd_expect_q.size() == 0) begin
        $error("unexpected result item, rank %h", out_rank_value);
        errors++;
      end else begin
        x = rd_expect_q.pop_front();
        if (out_rank_value !== x.rank) begin
          $error("rank_value expected %h actual %h", x.rank, out_rank_value);
          errors++;
        end
        if (out_passes_done !== x.passes) begin
          $error("passes_done expected %0d actual %0d", x.passes, out_passes_done);
          errors++;
        end
        if (out_converged !== x.conv) begin
          $error("converged expected %0d actual %0d", x.conv, out_converged);
          errors++;
        end
      end
    end
  end

  dir_row_t dir_rows [$];

  initial begin
    rst_n <= 1'b0;
    cfg_we <= 1'b0;
    cfg_index <= prcsr_pkg::REG_VCOUNT;
    cfg_data <= '0;
    in_valid <= 1'b0;
    in_op <= prcsr_pkg::OP_LOAD_ROW;
    in_index <= '0;
    in_value <= '0;
    m_vcount = 1;
    m_damp = 16'd55705;
    m_eps = 32'd4295;
    m_maxit = 16'd100;
    m_passes = 0;
    m_conv = 0;
    foreach (m_rank_ok[i]) m_rank_ok[i] = 0;
    repeat (9) @(posedge clk);
    rst_n <= 1'b1;
    @(posedge clk);

    // defaults, one vertex with a self loop; out-of-range slots are ignored
    dir_rows = '{
      '{prcsr_pkg::OP_READ,      14'd16383, 15'd0,     1, '{32'd0, 16'd0, 1'b0}},
      '{prcsr_pkg::OP_LOAD_ROW,  14'd0,     15'd0,     0, '0},
      '{prcsr_pkg::OP_LOAD_ROW,  14'd1,     15'd1,     0, '0},
      '{prcsr_pkg::OP_LOAD_ROW,  14'd1024,  15'd16384, 0, '0},
      '{prcsr_pkg::OP_LOAD_ROW,  14'd1025,  15'd5,     0, '0},
      '{prcsr_pkg::OP_LOAD_ROW,  14'd16383, 15'd32767, 0, '0},
      '{prcsr_pkg::OP_LOAD_EDGE, 14'd16383, 15'd32767, 0, '0},
      '{prcsr_pkg::OP_LOAD_EDGE, 14'd0,     15'd0,     0, '0},
      '{prcsr_pkg::OP_RUN,       14'd0,     15'd0,     0, '0},
      '{prcsr_pkg::OP_READ,      14'd0,     15'd0,     0, '0},
      '{prcsr_pkg::OP_READ,      14'd1,     15'd0,     0, '0},
      '{prcsr_pkg::OP_READ,      14'd16383, 15'd32767, 0, '0}
    };
    foreach (dir_rows[k])
      send(dir_rows[k].op, dir_rows[k].idx, dir_rows[k].val, dir_rows[k].typed,
           dir_rows[k].res);

    // offsets past the edge store and falling offsets: every vertex dangles
    set_config(11'd2, 16'hFFFF, 32'd0, 16'd3);
    send(prcsr_pkg::OP_LOAD_ROW, 0, 15'd20000);
    send(prcsr_pkg::OP_LOAD_ROW, 1, 15'd25000);
    send(prcsr_pkg::OP_LOAD_ROW, 2, 15'd3);
    send(prcsr_pkg::OP_RUN, 0, 0);
    send(prcsr_pkg::OP_READ, 0, 0);
    send(prcsr_pkg::OP_READ, 1, 0);
    send(prcsr_pkg::OP_READ, 2, 0, 1, '{32'd0, 16'd3, 1'b0});

    // vertex count too large, zero pass limit: ranks stay at 2^32/1024
    set_config(11'd2047, 16'd0, 32'hFFFF_FFFF, 16'd0);
    send(prcsr_pkg::OP_RUN, 0, 0);
    send(prcsr_pkg::OP_READ, 1023, 0, 1, '{32'h0040_0000, 16'd0, 1'b0});
    send(prcsr_pkg::OP_READ, 1024, 0, 1, '{32'd0, 16'd0, 1'b0});

    // vertex count zero, huge pass limit, loose epsilon: stops on pass one
    set_config(11'd0, 16'd0, 32'hFFFF_FFFF, 16'hFFFF);
    send(prcsr_pkg::OP_RUN, 0, 0);
    send(prcsr_pkg::OP_READ, 0, 0);

    for (int g = 0; n_items < ITEM_GOAL; g++) begin
      if (n_items > ITEM_GOAL - 80) quiet = 1;
      random_graph(g == 3);
    end
    in_valid <= 1'b0;
    wait (rd_expect_q.size() == 0);
    repeat (50) @(posedge clk);
    $display("%0d items sent: %0d runs and %0d rank reads checked over random CSR graphs",
             n_items, n_runs, n_reads);
    if (errors == 0) $display("Regression PASS");
    else $display("Regression FAIL");
    $finish;
  end
endmodule
